// File: hw/rtl/lowpass_feedback_comb_filter_assert.svh
// Assertion macros shared by the comb filter RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef LOWPASS_FEEDBACK_COMB_FILTER_ASSERT_SVH
`define LOWPASS_FEEDBACK_COMB_FILTER_ASSERT_SVH

`ifndef SYNTHESIS

`define LFCF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`define LFCF_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`else

`define LFCF_ASSERT(label, clk, rst, prop)

`define LFCF_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// File: hw/rtl/lfcf_pkg.sv
// Package for the lowpass feedback comb filter: constants, state and struct types.
// Used by lfcf_serial_mac, lfcf_delay_line and the top level; depends on nothing.
`timescale 1ns / 1ps

package lfcf_pkg;

   localparam int COEF_W     = 17;
   localparam int FRAC_W     = 16;
   localparam int LEN_W      = 13;
   localparam int MAC_CNT_W  = 5;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int ROUND_HALF = 32768;

   localparam logic [COEF_W-1:0] COEF_ONE      = 17'h10000;
   localparam logic [LEN_W-1:0]  LENGTH_RESET  = 13'd4096;

   localparam logic [1:0] REG_DAMPING  = 2'd0;
   localparam logic [1:0] REG_FEEDBACK = 2'd1;
   localparam logic [1:0] REG_LENGTH   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DAMP,
      ST_FEED,
      ST_WRITE
   } lfcf_state_type;

   typedef struct packed {
      logic rd;
      logic wr;
   } lfcf_dl_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } lfcf_mac_status_type;

endpackage

// File: hw/rtl/lfcf_serial_mac.sv
// Bit-serial multiply-accumulate: a*ca + b*cb, one coefficient bit per cycle, MSB first.
// Gives the sum rounded to the sample step. Depends on lfcf_pkg.
`timescale 1ns / 1ps
`include "lowpass_feedback_comb_filter_assert.svh"

module lfcf_serial_mac #(
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [lfcf_pkg::COEF_W-1:0]         coef_a,
   input  logic [lfcf_pkg::COEF_W-1:0]         coef_b,
   input  logic signed [SAMPLE_WIDTH-1:0]      op_a,
   input  logic signed [SAMPLE_WIDTH-1:0]      op_b,
   output lfcf_pkg::lfcf_mac_status_type       status,
   output logic signed [SAMPLE_WIDTH+1:0]      rnd
);

   localparam int AW = SAMPLE_WIDTH + lfcf_pkg::COEF_W + 1;

   logic [lfcf_pkg::COEF_W-1:0]    ca_ff, cb_ff;
   logic signed [SAMPLE_WIDTH-1:0] a_ff, b_ff;
   logic signed [AW-1:0]           acc_ff, acc_in;
   logic signed [AW-1:0]           pa, pb, rsum;
   logic [lfcf_pkg::MAC_CNT_W-1:0] cnt_ff;
   logic                           done_ff;

   always_comb begin
      pa     = ca_ff[lfcf_pkg::COEF_W-1] ? {{(AW-SAMPLE_WIDTH){a_ff[SAMPLE_WIDTH-1]}}, a_ff}
                                         : '0;
      pb     = cb_ff[lfcf_pkg::COEF_W-1] ? {{(AW-SAMPLE_WIDTH){b_ff[SAMPLE_WIDTH-1]}}, b_ff}
                                         : '0;
      acc_in = {acc_ff[AW-2:0], 1'b0} + pa + pb;
      rsum   = acc_ff + AW'(lfcf_pkg::ROUND_HALF);
   end

   assign rnd         = rsum[AW-1:lfcf_pkg::FRAC_W];
   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff  <= lfcf_pkg::MAC_CNT_W'(lfcf_pkg::COEF_W);
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == lfcf_pkg::MAC_CNT_W'(1));
         if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ca_ff  <= coef_a;
         cb_ff  <= coef_b;
         a_ff   <= op_a;
         b_ff   <= op_b;
         acc_ff <= '0;
      end else if (cnt_ff != '0) begin
         ca_ff  <= {ca_ff[lfcf_pkg::COEF_W-2:0], 1'b0};
         cb_ff  <= {cb_ff[lfcf_pkg::COEF_W-2:0], 1'b0};
         acc_ff <= acc_in;
      end
   end

   `LFCF_ASSERT(a_mac_done_after_run, clock, reset, done_ff |-> $past(cnt_ff) == lfcf_pkg::MAC_CNT_W'(1))
   `LFCF_ASSERT(a_mac_cnt_bounded, clock, reset, cnt_ff <= lfcf_pkg::MAC_CNT_W'(lfcf_pkg::COEF_W))
   `LFCF_ASSERT(a_mac_done_idle, clock, reset, done_ff |-> !status.busy)

endmodule

// File: hw/rtl/lfcf_delay_line.sv
// Delay line memory with write index, wrap at the programmed length and a fill count.
// Entries at or above the fill count read as zero. Depends on lfcf_pkg.
`timescale 1ns / 1ps
`include "lowpass_feedback_comb_filter_assert.svh"

module lfcf_delay_line #(
   parameter int MAX_DELAY    = 4096,
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lfcf_pkg::lfcf_dl_cmd_type      cmd,
   input  logic [lfcf_pkg::LEN_W-1:0]     len_cfg,
   input  logic [SAMPLE_WIDTH-1:0]        wr_data,
   output logic [SAMPLE_WIDTH-1:0]        rd_data
);

   localparam int IW = $clog2(MAX_DELAY);
   localparam int CW = (IW + 1 > lfcf_pkg::LEN_W) ? IW + 1 : lfcf_pkg::LEN_W;

   logic [SAMPLE_WIDTH-1:0] mem [MAX_DELAY];
   logic [SAMPLE_WIDTH-1:0] q_ff;
   logic                    hit_ff;
   logic [IW-1:0]           idx_ff, idx_in;
   logic [IW:0]             fill_ff, fill_in;
   logic [CW-1:0]           len_ext, len_eff, nxt;

   always_comb begin
      len_ext = CW'(len_cfg);
      if (len_ext == '0) begin
         len_eff = CW'(1);
      end else if (len_ext > CW'(MAX_DELAY)) begin
         len_eff = CW'(MAX_DELAY);
      end else begin
         len_eff = len_ext;
      end
      nxt     = CW'(idx_ff) + 1'b1;
      idx_in  = (nxt >= len_eff) ? '0 : nxt[IW-1:0];
      fill_in = (fill_ff == (IW+1)'(idx_ff)) ? fill_ff + 1'b1 : fill_ff;
   end

   assign rd_data = hit_ff ? q_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         fill_ff <= '0;
         hit_ff  <= 1'b0;
      end else begin
         if (cmd.rd) begin
            hit_ff <= ((IW+1)'(idx_ff) < fill_ff);
         end
         if (cmd.wr) begin
            idx_ff  <= idx_in;
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         q_ff <= mem[idx_ff];
      end
      if (cmd.wr) begin
         mem[idx_ff] <= wr_data;
      end
   end

   `LFCF_ASSERT(a_dl_idx_within_fill, clock, reset, (IW+1)'(idx_ff) <= fill_ff)
   `LFCF_ASSERT(a_dl_fill_bounded, clock, reset, fill_ff <= (IW+1)'(MAX_DELAY))
   `LFCF_ASSERT(a_dl_idx_steps, clock, reset, cmd.wr |=> (idx_ff == $past(idx_ff) + 1'b1) || (idx_ff == '0))

endmodule

// File: hw/rtl/lowpass_feedback_comb_filter.sv
// Lowpass feedback comb filter top level: handshakes, register port, sequencer, saturation.
// Depends on lfcf_pkg, lfcf_serial_mac and lfcf_delay_line.
`timescale 1ns / 1ps
`include "lowpass_feedback_comb_filter_assert.svh"

// Each accepted item returns the delay line entry at the write index, then feeds the
// lowpass state and writes sample_in + state*feedback_gain back, saturated. An item
// goes through the memory read, then two passes through the bit-serial multiplier (one
// coefficient bit per cycle), then the write, which needs the result side to be free
// and loads the result into its output register. No new item is taken before the
// write; the next one is taken after it, while the result waits in its output
// register; an item whose write comes while the previous result still waits holds
// there until that result is taken.
// Coefficients are Q1.16 and clamp at 1.0; the delay memory needs no clearing pass.
module lowpass_feedback_comb_filter #(
   parameter int MAX_DELAY    = 4096,
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_sample_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_sample_out,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lfcf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [lfcf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [lfcf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int RW = SAMPLE_WIDTH + 2;

   lfcf_pkg::lfcf_state_type        state_ff, state_in;
   lfcf_pkg::lfcf_dl_cmd_type       dl_cmd;
   lfcf_pkg::lfcf_mac_status_type   mac_st;

   logic [lfcf_pkg::COEF_W-1:0]     damping_ff, feedback_ff;
   logic [lfcf_pkg::LEN_W-1:0]      length_ff;
   logic [lfcf_pkg::COEF_W-1:0]     damp_c, feed_c, one_minus;
   logic signed [SAMPLE_WIDTH-1:0]  x_ff, y_ff, filt_ff, wr_ff, rsp_data_ff;
   logic                            rsp_valid_ff;
   logic [SAMPLE_WIDTH-1:0]         dl_rd_data;
   logic signed [RW-1:0]            mac_rnd, fb_sum;
   logic signed [SAMPLE_WIDTH-1:0]  filt_new, wr_new;
   logic                            mac_start, filt_load, wr_load, rsp_load, x_load;
   logic                            out_free, csr_wr;
   logic [lfcf_pkg::COEF_W-1:0]     mac_ca, mac_cb;
   logic signed [SAMPLE_WIDTH-1:0]  mac_a, mac_b;

   function automatic logic signed [SAMPLE_WIDTH-1:0] sat(input logic signed [RW-1:0] v);
      logic [RW-SAMPLE_WIDTH:0] top;
      top = v[RW-1:SAMPLE_WIDTH-1];
      if ((top == '0) || (top == '1)) begin
         return v[SAMPLE_WIDTH-1:0];
      end else if (v[RW-1]) begin
         return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      end else begin
         return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end
   endfunction

   // Configuration registers
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         damping_ff  <= '0;
         feedback_ff <= '0;
         length_ff   <= lfcf_pkg::LENGTH_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            lfcf_pkg::REG_DAMPING:  damping_ff  <= csr_pwdata[lfcf_pkg::COEF_W-1:0];
            lfcf_pkg::REG_FEEDBACK: feedback_ff <= csr_pwdata[lfcf_pkg::COEF_W-1:0];
            lfcf_pkg::REG_LENGTH:   length_ff   <= csr_pwdata[lfcf_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         lfcf_pkg::REG_DAMPING:  csr_prdata = lfcf_pkg::CSR_DATA_W'(damping_ff);
         lfcf_pkg::REG_FEEDBACK: csr_prdata = lfcf_pkg::CSR_DATA_W'(feedback_ff);
         lfcf_pkg::REG_LENGTH:   csr_prdata = lfcf_pkg::CSR_DATA_W'(length_ff);
         default:                csr_prdata = '0;
      endcase
   end

   // Coefficients and datapath selection
   always_comb begin
      damp_c    = (damping_ff > lfcf_pkg::COEF_ONE) ? lfcf_pkg::COEF_ONE : damping_ff;
      feed_c    = (feedback_ff > lfcf_pkg::COEF_ONE) ? lfcf_pkg::COEF_ONE : feedback_ff;
      one_minus = lfcf_pkg::COEF_ONE - damp_c;
      filt_new  = sat(mac_rnd);
      fb_sum    = RW'(x_ff) + mac_rnd;
      wr_new    = sat(fb_sum);
      if (state_ff == lfcf_pkg::ST_LOAD) begin
         mac_ca = one_minus;
         mac_cb = damp_c;
         mac_a  = $signed(dl_rd_data);
         mac_b  = filt_ff;
      end else begin
         mac_ca = feed_c;
         mac_cb = '0;
         mac_a  = filt_new;
         mac_b  = '0;
      end
   end

   // Sequencer: next state
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lfcf_pkg::ST_IDLE:  if (req_valid) state_in = lfcf_pkg::ST_LOAD;
         lfcf_pkg::ST_LOAD:  state_in = lfcf_pkg::ST_DAMP;
         lfcf_pkg::ST_DAMP:  if (mac_st.done) state_in = lfcf_pkg::ST_FEED;
         lfcf_pkg::ST_FEED:  if (mac_st.done) state_in = lfcf_pkg::ST_WRITE;
         lfcf_pkg::ST_WRITE: if (out_free) state_in = lfcf_pkg::ST_IDLE;
         default:            state_in = lfcf_pkg::ST_IDLE;
      endcase
   end

   // Sequencer: outputs
   always_comb begin
      req_stall = 1'b1;
      x_load    = 1'b0;
      dl_cmd    = '0;
      mac_start = 1'b0;
      filt_load = 1'b0;
      wr_load   = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         lfcf_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            x_load    = req_valid;
            dl_cmd.rd = req_valid;
         end
         lfcf_pkg::ST_LOAD: begin
            mac_start = 1'b1;
         end
         lfcf_pkg::ST_DAMP: begin
            mac_start = mac_st.done;
            filt_load = mac_st.done;
         end
         lfcf_pkg::ST_FEED: begin
            wr_load = mac_st.done;
         end
         lfcf_pkg::ST_WRITE: begin
            dl_cmd.wr = out_free;
            rsp_load  = out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfcf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         filt_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (filt_load) begin
            filt_ff <= filt_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (x_load) begin
         x_ff <= req_sample_in;
      end
      if (state_ff == lfcf_pkg::ST_LOAD) begin
         y_ff <= $signed(dl_rd_data);
      end
      if (wr_load) begin
         wr_ff <= wr_new;
      end
      if (rsp_load) begin
         rsp_data_ff <= y_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   lfcf_serial_mac #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .start   (mac_start),
      .coef_a  (mac_ca),
      .coef_b  (mac_cb),
      .op_a    (mac_a),
      .op_b    (mac_b),
      .status  (mac_st),
      .rnd     (mac_rnd)
   );

   lfcf_delay_line #(
      .MAX_DELAY    (MAX_DELAY),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_delay (
      .clock   (clock),
      .reset   (reset),
      .cmd     (dl_cmd),
      .len_cfg (length_ff),
      .wr_data (wr_ff),
      .rd_data (dl_rd_data)
   );

   `LFCF_ASSERT(a_rsp_from_write, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == lfcf_pkg::ST_WRITE))
   `LFCF_ASSERT(a_mac_done_in_math, clock, reset, mac_st.done |-> (state_ff == lfcf_pkg::ST_DAMP) || (state_ff == lfcf_pkg::ST_FEED))
   `LFCF_ASSERT(a_write_with_rsp, clock, reset, dl_cmd.wr |=> rsp_valid_ff)

endmodule
